// File: rtl/pokt_pkg.sv
// Shared types and codes for the parent-ordered key table.
// No dependencies. Used by the table core and its port checker.
`timescale 1ns / 1ps
`default_nettype none
package pokt_pkg;

  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int COUNT_BITS   = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_ZERO_KEY  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NO_PARENT = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

  typedef struct packed {
    cmd_t                           command;
    logic signed [KEY_BITS-1:0]     key;
    logic signed [KEY_BITS-1:0]     parent;
    logic        [PAYLOAD_BITS-1:0] payload;
  } in_item_t;

  typedef struct packed {
    status_t                        status;
    logic signed [KEY_BITS-1:0]     entry_key;
    logic signed [KEY_BITS-1:0]     entry_parent;
    logic        [PAYLOAD_BITS-1:0] entry_payload;
    logic        [COUNT_BITS-1:0]   entry_count;
    logic                           last;
  } out_item_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0]     key;
    logic signed [KEY_BITS-1:0]     parent;
    logic        [PAYLOAD_BITS-1:0] payload;
  } entry_t;

endpackage
`default_nettype wire

// File: rtl/parent_ordered_key_table_core.sv
// Parent-ordered key table: one entry memory walked by a small sequencer.
// Insert and find walk the entries, and insert then shifts entries up; delete
// runs an insertion sort over the memory; dump walks every entry.
// One item at a time; the single memory read port sets the pace.
// Reset (rst, synchronous): table empty, output register empty; memory keeps
// its contents but is never read beyond the fill count.
`timescale 1ns / 1ps
`default_nettype none
module parent_ordered_key_table_core
  import pokt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [16:0] {
    S_IDLE        = 17'h00001,
    S_SCAN_RD     = 17'h00002,
    S_SCAN_CHK    = 17'h00004,
    S_INS_RD      = 17'h00008,
    S_INS_CHK     = 17'h00010,
    S_INS_PUT     = 17'h00020,
    S_ZERO_RD     = 17'h00040,
    S_ZERO_WR     = 17'h00080,
    S_SORT_RD     = 17'h00100,
    S_SORT_TMP    = 17'h00200,
    S_SORT_CMP_RD = 17'h00400,
    S_SORT_CMP    = 17'h00800,
    S_DEL_RD      = 17'h01000,
    S_DEL_WR      = 17'h02000,
    S_DUMP_RD     = 17'h04000,
    S_DUMP_OUT    = 17'h08000,
    S_DONE        = 17'h10000
  } state_t;

  typedef enum logic [4:0] {
    P_DUP  = 5'b00001,
    P_PAR  = 5'b00010,
    P_FIND = 5'b00100,
    P_DEL  = 5'b01000,
    P_POS  = 5'b10000
  } phase_t;

  state_t          state;
  phase_t          phase;
  in_item_t        cur;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic signed [KEY_BITS-1:0] scan_key;
  entry_t          tmp;
  status_t         res_status;
  entry_t          res_entry;

  entry_t          mem [TABLE_DEPTH];
  entry_t          rdata;
  logic            rd_en;
  logic [IDX_W-1:0] raddr;
  logic            we;
  logic [IDX_W-1:0] waddr;
  entry_t          wdata;

  logic [CNT_W-1:0] im1, jm1, ip1;
  logic            out_free;
  logic            out_load;
  logic            ins_gt, sort_gt;
  entry_t          new_entry, zeroed;

  assign im1 = i - 1'b1;
  assign jm1 = j - 1'b1;
  assign ip1 = i + 1'b1;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((state == S_DONE) || (state == S_DUMP_OUT));
  assign in_stall = (state != S_IDLE);
  assign ins_gt  = $signed(rdata.parent) > $signed(cur.parent);
  assign sort_gt = $signed(rdata.parent) > $signed(tmp.parent);
  assign new_entry = '{key: cur.key, parent: cur.parent, payload: cur.payload};

  always_comb begin
    zeroed = rdata;
    zeroed.parent = '0;
  end

  // memory port control
  always_comb begin
    rd_en = 1'b0;
    raddr = i[IDX_W-1:0];
    we    = 1'b0;
    waddr = i[IDX_W-1:0];
    wdata = rdata;
    case (state)
      S_SCAN_RD, S_ZERO_RD: begin
        rd_en = (i != used);
      end
      S_INS_RD: begin
        rd_en = (i != '0);
        raddr = im1[IDX_W-1:0];
      end
      S_INS_CHK: begin
        we = ins_gt;
      end
      S_INS_PUT: begin
        we    = 1'b1;
        wdata = new_entry;
      end
      S_ZERO_WR: begin
        we    = (rdata.parent == cur.key);
        wdata = zeroed;
      end
      S_SORT_RD: begin
        rd_en = (i < used);
      end
      S_SORT_CMP_RD: begin
        waddr = j[IDX_W-1:0];
        wdata = tmp;
        raddr = jm1[IDX_W-1:0];
        we    = (j == '0);
        rd_en = (j != '0);
      end
      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = j[IDX_W-1:0];
        wdata = sort_gt ? rdata : tmp;
      end
      S_DEL_RD: begin
        rd_en = (ip1 < used);
        raddr = ip1[IDX_W-1:0];
      end
      S_DEL_WR: begin
        we = 1'b1;
      end
      S_DUMP_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur        <= in;
            scan_key   <= in.key;
            i          <= '0;
            res_entry  <= '0;
            res_status <= ST_OK;
            case (in.command)
              CMD_INSERT: begin
                phase <= P_DUP;
                if (used >= DEPTH_C) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (in.key == '0) begin
                  res_status <= ST_ZERO_KEY;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              CMD_FIND: begin
                phase <= P_FIND;
                if (in.key == '0) begin
                  res_status <= ST_ZERO_KEY;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              CMD_DELETE: begin
                phase <= P_DEL;
                if (used == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else if (in.key == '0) begin
                  res_status <= ST_ZERO_KEY;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              CMD_DUMP: begin
                if (used == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_DUMP_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_SCAN_RD: begin
          if (i != used) begin
            state <= S_SCAN_CHK;
          end else begin
            // key not present
            case (phase)
              P_DUP: begin
                if (cur.parent == '0) begin
                  i     <= used;
                  state <= S_INS_RD;
                end else begin
                  scan_key <= cur.parent;
                  phase    <= P_PAR;
                  i        <= '0;
                end
              end
              P_PAR: begin
                res_status <= ST_NO_PARENT;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN_CHK: begin
          if (rdata.key == scan_key) begin
            case (phase)
              P_DUP: begin
                res_status <= ST_DUPLICATE;
                state      <= S_DONE;
              end
              P_PAR: begin
                i     <= used;
                state <= S_INS_RD;
              end
              P_FIND: begin
                res_entry <= rdata;
                state     <= S_DONE;
              end
              P_DEL: begin
                i     <= '0;
                state <= S_ZERO_RD;
              end
              default: begin
                // i already holds the slot to remove
                state <= S_DEL_RD;
              end
            endcase
          end else begin
            i     <= ip1;
            state <= S_SCAN_RD;
          end
        end

        S_INS_RD: begin
          state <= (i == '0) ? S_INS_PUT : S_INS_CHK;
        end

        S_INS_CHK: begin
          if (ins_gt) begin
            i     <= im1;
            state <= S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end

        S_INS_PUT: begin
          used  <= used + 1'b1;
          state <= S_DONE;
        end

        S_ZERO_RD: begin
          if (i != used) begin
            state <= S_ZERO_WR;
          end else begin
            i     <= CNT_W'(1);
            state <= S_SORT_RD;
          end
        end

        S_ZERO_WR: begin
          i     <= ip1;
          state <= S_ZERO_RD;
        end

        S_SORT_RD: begin
          if (i < used) begin
            state <= S_SORT_TMP;
          end else begin
            scan_key <= cur.key;
            phase    <= P_POS;
            i        <= '0;
            state    <= S_SCAN_RD;
          end
        end

        S_SORT_TMP: begin
          tmp   <= rdata;
          j     <= i;
          state <= S_SORT_CMP_RD;
        end

        S_SORT_CMP_RD: begin
          if (j == '0) begin
            i     <= ip1;
            state <= S_SORT_RD;
          end else begin
            state <= S_SORT_CMP;
          end
        end

        S_SORT_CMP: begin
          if (sort_gt) begin
            j     <= jm1;
            state <= S_SORT_CMP_RD;
          end else begin
            i     <= ip1;
            state <= S_SORT_RD;
          end
        end

        S_DEL_RD: begin
          if (ip1 < used) begin
            state <= S_DEL_WR;
          end else begin
            used  <= used - 1'b1;
            state <= S_DONE;
          end
        end

        S_DEL_WR: begin
          i     <= ip1;
          state <= S_DEL_RD;
        end

        S_DUMP_RD: begin
          state <= S_DUMP_OUT;
        end

        S_DUMP_OUT: begin
          if (out_free) begin
            out.status        <= ST_OK;
            out.entry_key     <= rdata.key;
            out.entry_parent  <= rdata.parent;
            out.entry_payload <= rdata.payload;
            out.entry_count   <= COUNT_BITS'(used);
            out.last          <= (ip1 == used);
            i                 <= ip1;
            state             <= (ip1 == used) ? S_IDLE : S_DUMP_RD;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out.status        <= res_status;
            out.entry_key     <= res_entry.key;
            out.entry_parent  <= res_entry.parent;
            out.entry_payload <= res_entry.payload;
            out.entry_count   <= COUNT_BITS'(used);
            out.last          <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/pokt_checker.sv
// Port-level checks for the parent-ordered key table, bound to the core.
// Depends on pokt_pkg and parent_ordered_key_table_core.
`timescale 1ns / 1ps
`default_nettype none
module pokt_checker
  import pokt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out))
    else $error("stalled output item changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (TABLE_DEPTH > 31) || (out.entry_count <= COUNT_BITS'(TABLE_DEPTH)))
    else $error("entry count above table depth");

  // error items are single, final and carry no entry
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.status != ST_OK |->
      out.last && out.entry_key == '0 && out.entry_parent == '0 &&
      out.entry_payload == '0)
    else $error("malformed error item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting an item");

endmodule

bind parent_ordered_key_table_core pokt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_pokt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out(out)
);
`default_nettype wire
